// ----- design/dip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_pkg
// Shared types and constants for the ASCII decimal integer parser.
// ----------------------------------------------------------------------------
package dip_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_NUMBER_FORMAT = 1'b0;
   localparam logic REG_MAX_CHARS     = 1'b1;

   localparam logic [1:0] FMT_S32 = 2'd0;
   localparam logic [1:0] FMT_S64 = 2'd1;
   localparam logic [1:0] FMT_U32 = 2'd2;

   localparam logic [1:0] FORMAT_RESET    = FMT_S32;
   localparam logic [7:0] MAX_CHARS_RESET = 8'd255;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;

   typedef struct packed {
      logic [1:0] number_format;
      logic [7:0] max_chars;
   } cfg_type;

endpackage

// ----- design/dip_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_csr
// APB-style register file: number format and character limit.
// ----------------------------------------------------------------------------
module dip_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [dip_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dip_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dip_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output dip_pkg::cfg_type               cfg
);

   logic [1:0] format_ff;
   logic [1:0] format_in;
   logic [7:0] max_chars_ff;
   logic [7:0] max_chars_in;
   logic       wr_en;
   logic       reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      format_in    = format_ff;
      max_chars_in = max_chars_ff;
      if (wr_en) begin
         unique case (reg_sel)
            dip_pkg::REG_NUMBER_FORMAT: format_in    = csr_pwdata[1:0];
            dip_pkg::REG_MAX_CHARS:     max_chars_in = csr_pwdata[7:0];
            default:                    format_in    = format_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= dip_pkg::FORMAT_RESET;
         max_chars_ff <= dip_pkg::MAX_CHARS_RESET;
      end else begin
         format_ff    <= format_in;
         max_chars_ff <= max_chars_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         dip_pkg::REG_NUMBER_FORMAT: csr_prdata = {30'd0, format_ff};
         dip_pkg::REG_MAX_CHARS:     csr_prdata = {24'd0, max_chars_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   assign cfg.number_format = format_ff;
   assign cfg.max_chars     = max_chars_ff;

endmodule

// ----- design/dip_accum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_accum
// Per-string parse state, one character per cycle while step is high, and the result register.
// ----------------------------------------------------------------------------
module dip_accum (
   input  logic             clock,
   input  logic             reset,
   input  dip_pkg::cfg_type cfg,
   input  logic             step,
   input  logic [7:0]       step_char,
   input  logic             step_last,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [63:0]      rsp_parsed_value,
   output logic             rsp_parse_error,
   output logic             rsp_overflowed
);

   logic [63:0] magnitude_ff, magnitude_in;
   logic        negative_ff, negative_in;
   logic [7:0]  chars_seen_ff, chars_seen_in;
   logic        stopped_ff, stopped_in;
   logic        error_ff, error_in;
   logic        overflow_ff, overflow_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] value_ff, value_in;
   logic        perr_ff, perr_in;
   logic        povf_ff, povf_in;

   logic        is_signed;
   logic        is_wide;
   logic        is_digit;
   logic [7:0]  digit_diff;
   logic [67:0] mag_next;
   logic [63:0] signed_mag;

   assign is_signed  = (cfg.number_format == dip_pkg::FMT_S32) ||
                       (cfg.number_format == dip_pkg::FMT_S64);
   assign is_wide    = (cfg.number_format == dip_pkg::FMT_S64);
   assign is_digit   = (step_char >= dip_pkg::CHAR_ZERO) && (step_char <= dip_pkg::CHAR_NINE);
   assign digit_diff = step_char - dip_pkg::CHAR_ZERO;
   // x*10 + d as shift-add, four guard bits to catch overflow
   assign mag_next   = ({4'd0, magnitude_ff} << 3) + ({4'd0, magnitude_ff} << 1)
                       + {64'd0, digit_diff[3:0]};

   always_comb begin
      magnitude_in  = magnitude_ff;
      negative_in   = negative_ff;
      chars_seen_in = chars_seen_ff;
      stopped_in    = stopped_ff;
      error_in      = error_ff;
      overflow_in   = overflow_ff;
      if (step && !stopped_ff) begin
         priority if (step_char == dip_pkg::CHAR_NUL || chars_seen_ff >= cfg.max_chars) begin
            stopped_in = 1'b1;
         end else begin
            chars_seen_in = chars_seen_ff + 8'd1;
            priority if (step_char == dip_pkg::CHAR_MINUS && is_signed) begin
               if (negative_ff) begin
                  error_in   = 1'b1;
                  stopped_in = 1'b1;
               end else begin
                  negative_in = 1'b1;
               end
            end else if (!is_digit) begin
               error_in   = 1'b1;
               stopped_in = 1'b1;
            end else begin
               magnitude_in = mag_next[63:0];
               if (is_wide ? (|mag_next[67:64]) : (|mag_next[67:32])) begin
                  overflow_in = 1'b1;
               end
            end
         end
      end
   end

   assign signed_mag = negative_in ? (64'd0 - magnitude_in) : magnitude_in;

   always_comb begin
      unique case (cfg.number_format)
         dip_pkg::FMT_S64: value_in = signed_mag;
         dip_pkg::FMT_S32: value_in = {{32{signed_mag[31]}}, signed_mag[31:0]};
         default:          value_in = {32'd0, magnitude_in[31:0]};
      endcase
   end

   assign perr_in      = error_in;
   assign povf_in      = overflow_in;
   assign rsp_valid_in = (step && step_last) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset || (step && step_last)) begin
         magnitude_ff  <= '0;
         negative_ff   <= 1'b0;
         chars_seen_ff <= '0;
         stopped_ff    <= 1'b0;
         error_ff      <= 1'b0;
         overflow_ff   <= 1'b0;
      end else begin
         magnitude_ff  <= magnitude_in;
         negative_ff   <= negative_in;
         chars_seen_ff <= chars_seen_in;
         stopped_ff    <= stopped_in;
         error_ff      <= error_in;
         overflow_ff   <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && step_last) begin
         value_ff <= value_in;
         perr_ff  <= perr_in;
         povf_ff  <= povf_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parsed_value = value_ff;
   assign rsp_parse_error  = perr_ff;
   assign rsp_overflowed   = povf_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && step_last |=> chars_seen_ff == 8'd0 && !stopped_ff && magnitude_ff == 64'd0)
      else $error("string state not cleared after last character");

   a_error_stops: assert property (@(posedge clock) disable iff (reset)
      error_ff |-> stopped_ff)
      else $error("error flagged without parsing stopped");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !(step && step_last))
      else $error("pending result overwritten");

endmodule

// ----- design/decimal_integer_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_integer_parser
// Parses ASCII decimal strings, one character per transaction, into integers.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, limited by the multiply-by-ten state
//   update; a last character waits while a result is still pending.
// Result path: the last character passes the input register (s1), then the
//   result register; rsp_valid rises when the result register is loaded.
// Reset: synchronous; clears parse state and pipeline, number_format to 0,
//   max_chars to 255.
module decimal_integer_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_text_char,
   input  logic                           req_end_of_string,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [63:0]             rsp_parsed_value,
   output logic                           rsp_parse_error,
   output logic                           rsp_overflowed,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [dip_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dip_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dip_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   dip_pkg::cfg_type cfg;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_char_ff;
   logic        s1_last_ff;
   logic        out_free;
   logic        step;
   logic [63:0] value;

   dip_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // last character waits until the result slot is free
   assign out_free    = !rsp_valid || rsp_ready;
   assign step        = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready   = !s1_valid_ff || step;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_char_ff <= req_text_char;
         s1_last_ff <= req_end_of_string;
      end
   end

   dip_accum u_accum (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .step             (step),
      .step_char        (s1_char_ff),
      .step_last        (s1_last_ff),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_parsed_value (value),
      .rsp_parse_error  (rsp_parse_error),
      .rsp_overflowed   (rsp_overflowed)
   );

   assign rsp_parsed_value = $signed(value);

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !step |=> s1_valid_ff && $stable(s1_char_ff) && $stable(s1_last_ff))
      else $error("stalled character lost from input register");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("input not ready with empty input register");

endmodule

// ----- tb/tb_decimal_integer_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_integer_parser
// Self-checking bench for the ASCII decimal integer parser. A short table of
// directed strings and register writes comes first; its results are typed in
// and checked directly, every random result against a behavioral model of the
// parser. Random phases then vary the number format and character limit and
// send digit strings, boundary numbers, overflow runs and noise, with random
// gaps on both channels and one long stall on the result side.
// ----------------------------------------------------------------------------
module tb_decimal_integer_parser;

   localparam logic [1:0] FMT_SPARE      = 2'd3;
   localparam int         SETTLE_CYCLES  = 6;
   localparam int         HOLDOFF_CYCLES = 120;
   localparam int         PHASE_ITEMS    = 125;
   localparam int         CYCLE_LIMIT    = 400000;

   typedef enum logic [1:0] {ROW_CHAR, ROW_SET_FORMAT, ROW_SET_MAX} row_kind_type;

   typedef struct packed {
      logic [63:0] value;
      logic        err;
      logic        ovf;
   } parse_result_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   data;
      logic         last;
      logic         typed;
      logic [63:0]  value;
      logic         err;
      logic         ovf;
   } directed_row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [7:0]                       req_text_char;
   logic                             req_end_of_string;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic signed [63:0]               rsp_parsed_value;
   logic                             rsp_parse_error;
   logic                             rsp_overflowed;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [dip_pkg::CSR_ADDR_W-1:0]   csr_paddr;
   logic [dip_pkg::CSR_DATA_W-1:0]   csr_pwdata;
   logic [dip_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                             csr_pready;

   // parser state mirror
   logic [1:0]  fmt_setting       = dip_pkg::FORMAT_RESET;
   logic [7:0]  max_chars_setting = dip_pkg::MAX_CHARS_RESET;
   logic [63:0] acc_magnitude     = '0;
   logic        acc_negative      = 1'b0;
   logic [7:0]  acc_count         = '0;
   logic        acc_halted        = 1'b0;
   logic        acc_error         = 1'b0;
   logic        acc_overflow      = 1'b0;

   parse_result_type pending_results [$];
   int               mismatches      = 0;
   int               cycle_count     = 0;
   logic             gaps_on         = 1'b1;
   logic             holdoff_request = 1'b0;

   directed_row_type directed_rows [34] = '{
      '{ROW_CHAR,       "7",                  1'b1, 1'b1, 64'd7,           1'b0, 1'b0},
      '{ROW_CHAR,       "-",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "9",                  1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFF7,
        1'b0, 1'b0},
      '{ROW_CHAR,       8'hFF,                1'b1, 1'b1, 64'd0,           1'b1, 1'b0},
      '{ROW_CHAR,       dip_pkg::CHAR_NUL,    1'b1, 1'b1, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "-",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "-",                  1'b1, 1'b1, 64'd0,           1'b1, 1'b0},
      '{ROW_CHAR,       "/",                  1'b1, 1'b1, 64'd0,           1'b1, 1'b0},
      '{ROW_SET_FORMAT, 8'(dip_pkg::FMT_U32), 1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "-",                  1'b1, 1'b1, 64'd0,           1'b1, 1'b0},
      '{ROW_CHAR,       "4",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "2",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "9",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "4",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "9",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "6",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "7",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "2",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "9",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "6",                  1'b1, 1'b1, 64'd0,           1'b0, 1'b1},
      '{ROW_SET_FORMAT, 8'(FMT_SPARE),        1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "-",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "1",                  1'b1, 1'b1, 64'd0,           1'b1, 1'b0},
      '{ROW_SET_MAX,    8'd0,                 1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "5",                  1'b1, 1'b1, 64'd0,           1'b0, 1'b0},
      '{ROW_SET_MAX,    8'd1,                 1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_SET_FORMAT, 8'(dip_pkg::FMT_S64), 1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "1",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "2",                  1'b1, 1'b1, 64'd1,           1'b0, 1'b0},
      '{ROW_SET_MAX,    8'd255,               1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "-",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "3",                  1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_SET_FORMAT, 8'(dip_pkg::FMT_U32), 1'b0, 1'b0, 64'd0,           1'b0, 1'b0},
      '{ROW_CHAR,       "4",                  1'b1, 1'b1, 64'd34,          1'b0, 1'b0}
   };

   decimal_integer_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_char     (req_text_char),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_parsed_value  (rsp_parsed_value),
      .rsp_parse_error   (rsp_parse_error),
      .rsp_overflowed    (rsp_overflowed),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR @%0t: %s got %h expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // one character into the parser state; returns the result on the last one
   function automatic void accumulate_char(input logic [7:0] ch, input logic last,
                                           output logic produced,
                                           output parse_result_type res);
      logic        is_signed;
      logic [63:0] limit;
      logic [63:0] digit;
      logic [63:0] signed_mag;
      is_signed = (fmt_setting == dip_pkg::FMT_S32) || (fmt_setting == dip_pkg::FMT_S64);
      limit     = (fmt_setting == dip_pkg::FMT_S64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                    : 64'hFFFF_FFFF;
      produced  = 1'b0;
      res       = '0;
      if (!acc_halted) begin
         if (ch == dip_pkg::CHAR_NUL || acc_count >= max_chars_setting) begin
            acc_halted = 1'b1;
         end else begin
            acc_count = acc_count + 8'd1;
            if (ch == dip_pkg::CHAR_MINUS && is_signed) begin
               if (acc_negative) begin
                  acc_error  = 1'b1;
                  acc_halted = 1'b1;
               end else begin
                  acc_negative = 1'b1;
               end
            end else if (ch < dip_pkg::CHAR_ZERO || ch > dip_pkg::CHAR_NINE) begin
               acc_error  = 1'b1;
               acc_halted = 1'b1;
            end else begin
               digit = 64'(ch - dip_pkg::CHAR_ZERO);
               if (acc_magnitude > (limit - digit) / 64'd10)
                  acc_overflow = 1'b1;
               acc_magnitude = acc_magnitude * 64'd10 + digit;
            end
         end
      end
      if (last) begin
         signed_mag = acc_negative ? 64'd0 - acc_magnitude : acc_magnitude;
         if (fmt_setting == dip_pkg::FMT_S64)
            res.value = signed_mag;
         else if (fmt_setting == dip_pkg::FMT_S32)
            res.value = {{32{signed_mag[31]}}, signed_mag[31:0]};
         else
            res.value = {32'd0, acc_magnitude[31:0]};
         res.err       = acc_error;
         res.ovf       = acc_overflow;
         produced      = 1'b1;
         acc_magnitude = '0;
         acc_negative  = 1'b0;
         acc_count     = '0;
         acc_halted    = 1'b0;
         acc_error     = 1'b0;
         acc_overflow  = 1'b0;
      end
   endfunction

   function automatic logic [7:0] random_digit();
      return dip_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_char(input logic [7:0] ch, input logic last, input logic typed,
                            input parse_result_type typed_result);
      logic             produced;
      parse_result_type model_result;
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_text_char     <= ch;
      req_end_of_string <= last;
      do @(posedge clock); while (!req_ready);
      accumulate_char(ch, last, produced, model_result);
      if (produced)
         pending_results.push_back(typed ? typed_result : model_result);
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write then read back one register
   task automatic csr_write(input logic reg_index, input logic [7:0] data);
      logic [dip_pkg::CSR_DATA_W-1:0] readback;
      readback = (reg_index == dip_pkg::REG_NUMBER_FORMAT) ? {30'd0, data[1:0]}
                                                           : {24'd0, data};
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= {24'd0, data};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (reg_index == dip_pkg::REG_NUMBER_FORMAT)
         fmt_setting = data[1:0];
      else
         max_chars_setting = data;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== readback)
         report_mismatch("register readback", 64'(csr_prdata), 64'(readback));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random_string(output int sent);
      logic [7:0]  text [$];
      logic [63:0] anchor;
      string       digits;
      int          style;
      style = $urandom_range(0, 9);
      anchor = '0;
      case (style)
         6: repeat ($urandom_range(11, 24)) text.push_back(random_digit());
         7: begin
            case ($urandom_range(0, 3))
               0: anchor = 64'd2147483647 + $urandom_range(0, 2);
               1: anchor = 64'd4294967295 + $urandom_range(0, 2);
               2: anchor = 64'd9223372036854775807 + $urandom_range(0, 2);
               default: anchor = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 2);
            endcase
            digits = $sformatf("%0d", anchor);
            for (int i = 0; i < digits.len(); i++)
               text.push_back(digits[i]);
            if ($urandom_range(0, 2) == 0)
               text.push_back(random_digit());
         end
         8: repeat ($urandom_range(1, 8)) text.push_back(8'($urandom));
         9: begin
            repeat ($urandom_range(0, 5)) text.push_back(random_digit());
            text.push_back($urandom_range(0, 1) ? dip_pkg::CHAR_NUL : 8'($urandom));
            repeat ($urandom_range(0, 4)) text.push_back(8'($urandom));
         end
         default:
            repeat ($urandom_range(1, 10))
               text.push_back(($urandom_range(0, 39) == 0) ? 8'($urandom) : random_digit());
      endcase
      if ($urandom_range(0, 2) == 0)
         text.insert($urandom_range(0, text.size() - 1), dip_pkg::CHAR_MINUS);
      if ($urandom_range(0, 9) == 0)
         text.insert($urandom_range(0, text.size() - 1), dip_pkg::CHAR_MINUS);
      foreach (text[i])
         send_char(text[i], i == text.size() - 1, 1'b0, '0);
      sent = text.size();
   endtask

   initial begin : result_ready_drive
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES - 1) @(negedge clock);
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      parse_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_parsed_value, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_parsed_value !== want.value)
               report_mismatch("parsed_value", rsp_parsed_value, want.value);
            if (rsp_parse_error !== want.err)
               report_mismatch("parse_error", 64'(rsp_parse_error), 64'(want.err));
            if (rsp_overflowed !== want.ovf)
               report_mismatch("overflowed", 64'(rsp_overflowed), 64'(want.ovf));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      parse_result_type typed_result;
      logic [1:0]       phase_format;
      logic [7:0]       phase_max;
      int               phase_items;
      int               quota;
      int               sent;
      logic             holdoff_done;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_text_char     = '0;
      req_end_of_string = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      holdoff_done      = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_CHAR: begin
               typed_result.value = directed_rows[i].value;
               typed_result.err   = directed_rows[i].err;
               typed_result.ovf   = directed_rows[i].ovf;
               send_char(directed_rows[i].data, directed_rows[i].last,
                         directed_rows[i].typed, typed_result);
            end
            ROW_SET_FORMAT: begin
               wait_quiet();
               csr_write(dip_pkg::REG_NUMBER_FORMAT, directed_rows[i].data);
            end
            default: begin
               wait_quiet();
               csr_write(dip_pkg::REG_MAX_CHARS, directed_rows[i].data);
            end
         endcase
      end

      for (int phase = 0; phase < 8; phase++) begin
         phase_format = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
         case (phase)
            0: phase_max = 8'd255;
            1: phase_max = 8'd1;
            2: phase_max = 8'd0;
            default:
               case ($urandom_range(0, 3))
                  0: phase_max = 8'd255;
                  1: phase_max = 8'($urandom_range(1, 12));
                  2: phase_max = 8'($urandom_range(13, 254));
                  default: phase_max = 8'($urandom_range(2, 30));
               endcase
         endcase
         // leave a string open across the register update now and then
         if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 3)) send_char(random_digit(), 1'b0, 1'b0, '0);
         wait_quiet();
         gaps_on = (phase != 7) && ($urandom_range(0, 3) != 0);
         csr_write(dip_pkg::REG_NUMBER_FORMAT, {6'd0, phase_format});
         csr_write(dip_pkg::REG_MAX_CHARS, phase_max);
         quota = (phase_max == 8'd0) ? 30 : PHASE_ITEMS;
         phase_items = 0;
         while (phase_items < quota) begin
            send_random_string(sent);
            phase_items += sent;
            if (phase == 4 && !holdoff_done && phase_items >= 40) begin
               holdoff_request = 1'b1;
               holdoff_done    = 1'b1;
            end
         end
      end

      wait_quiet();
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- decimal_integer_parser.f -----
design/dip_pkg.sv
design/dip_csr.sv
design/dip_accum.sv
design/decimal_integer_parser.sv
tb/tb_decimal_integer_parser.sv
